// File: rtl/tga_rle_pkg.sv
// Shared types, codes and result packing for the TGA run-length pixel decoder.
package tga_rle_pkg;

	// Largest image the decoder accepts; a bigger total_pixels is clamped to it
	localparam int unsigned MaxPixels = 65536;

	localparam int PixCntW = 17;

	// Packet parser phases
	localparam logic [1:0] PH_HDR = 2'd0;
	localparam logic [1:0] PH_LIT = 2'd1;
	localparam logic [1:0] PH_RUN = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_RLE_MODE  = 2'd0;
	localparam logic [1:0] CFG_FOUR_CH   = 2'd1;
	localparam logic [1:0] CFG_TOTAL_PIX = 2'd2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] RUN_FLAG_BIT = 8'h80;

	typedef struct packed {
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
		logic [15:0]        first_pixel;
		logic [PixCntW-1:0] repeat_res;
		logic               image_done;
	} result_t;

	// BGR(A) pixel word to an RGBA run record
	function automatic result_t make_result(logic [31:0] pix, logic four_ch,
			logic [PixCntW-1:0] first, logic [PixCntW-1:0] rep);
		result_t r;
		r.red         = pix[23:16];
		r.green       = pix[15:8];
		r.blue        = pix[7:0];
		r.alpha       = four_ch ? pix[31:24] : ALPHA_OPAQUE;
		r.first_pixel = first[15:0];
		r.repeat_res  = rep;
		r.image_done  = 1'b0;
		return r;
	endfunction

endpackage

// File: rtl/tga_rle_pixel_decoder_core.sv
// TGA run-length pixel decoder (24/32 bpp): payload bytes in, RGBA pixel runs out.
// A byte's results pass through the input register and then the result queue before they appear.
// Throughput: one byte per cycle, held by byte_stall when the four-entry result queue has under
// two entries free; an image's last byte may give two results, drained one per unstalled cycle.
// Reset: parser state, pixel count and queue are cleared; registers return to rle_mode=1,
// four_channels=0, total_pixels=1. Decode state also clears after every last_byte.
module tga_rle_pixel_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	// payload byte channel
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	// pixel run channel
	output logic        pix_valid,
	input  logic        pix_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [15:0] first_pixel,
	output logic [16:0] repeat_res,
	output logic        image_done
);
	import tga_rle_pkg::*;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// configuration registers
	logic               rle_mode_q;
	logic               four_channels_q;
	logic [PixCntW-1:0] total_pixels_q;

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// decode state
	logic [1:0]         phase_q;
	logic [9:0]         left_q;
	logic [7:0]         run_len_q;
	logic [1:0]         bip_q;
	logic [31:0]        pix_q;
	logic [PixCntW-1:0] done_q;

	// result queue
	result_t            q_mem [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QCntW-1:0]   count_q;

	logic byte_acc;
	logic proc;
	logic pop;

	// next-state and result logic
	logic [1:0]         phase_d;
	logic [9:0]         left_d;
	logic [7:0]         run_len_d;
	logic [1:0]         bip_d;
	logic [31:0]        pix_d;
	logic [PixCntW-1:0] done_d;
	logic [PixCntW-1:0] total;
	logic               active;
	logic [31:0]        pix_or;
	logic [2:0]         bip_inc;
	logic               px_full;
	logic               proc_put;
	logic [PixCntW-1:0] proc_rep;
	logic [PixCntW-1:0] remaining;
	logic [PixCntW-1:0] run_ext;
	logic [7:0]         hdr_len;
	logic [PixCntW-1:0] done1;
	logic [PixCntW-1:0] done2;
	logic [PixCntW-1:0] done3;
	logic               part_put;
	logic               fill_put;
	logic [PixCntW-1:0] fill_rep;
	logic [1:0]         n_res;
	result_t            res_a;
	result_t            res_b;
	result_t            fill_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_mode_q      <= 1'b1;
			four_channels_q <= 1'b0;
			total_pixels_q  <= PixCntW'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RLE_MODE:  rle_mode_q      <= cfg_data[0];
				CFG_FOUR_CH:   four_channels_q <= cfg_data[0];
				CFG_TOTAL_PIX: total_pixels_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input register is processed once the queue has room for two results.
	assign proc       = valid_s1 && (count_q <= QCntW'(QDepth - 2));
	assign byte_stall = valid_s1 && !proc;
	assign byte_acc   = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_acc) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		total = (32'(total_pixels_q) > 32'(MaxPixels)) ? PixCntW'(MaxPixels) : total_pixels_q;
		active = done_q < total;
		remaining = total - done_q;

		// colour byte lands in the lane picked by its position in the pixel
		pix_or  = pix_q | (32'(data_s1) << {bip_q, 3'b000});
		bip_inc = {1'b0, bip_q} + 3'd1;
		px_full = four_channels_q ? (bip_inc >= 3'd4) : (bip_inc >= 3'd3);

		run_ext = PixCntW'(run_len_q);
		hdr_len = {1'b0, data_s1[6:0]} + 8'd1;

		phase_d   = phase_q;
		left_d    = left_q;
		run_len_d = run_len_q;
		bip_d     = bip_q;
		pix_d     = pix_q;
		proc_put  = 1'b0;
		proc_rep  = PixCntW'(1);

		if (active) begin
			if (!rle_mode_q || phase_q == PH_LIT || phase_q == PH_RUN) begin
				bip_d = px_full ? 2'd0 : bip_inc[1:0];
				pix_d = px_full ? 32'd0 : pix_or;
				proc_put = px_full && (!rle_mode_q || phase_q == PH_LIT);
			end
			if (rle_mode_q) begin
				unique case (phase_q)
					PH_LIT: begin
						if (left_q != 10'd0) begin
							left_d = left_q - 10'd1;
						end
						if (left_q <= 10'd1) begin
							phase_d = PH_HDR;
						end
					end
					PH_RUN: begin
						if (px_full) begin
							// clip the run to what is still missing
							proc_rep = (run_ext > remaining) ? remaining : run_ext;
							if (proc_rep == '0) begin
								proc_rep = PixCntW'(1);
							end
							proc_put = 1'b1;
							phase_d  = PH_HDR;
						end
					end
					default: begin
						run_len_d = hdr_len;
						bip_d     = 2'd0;
						pix_d     = 32'd0;
						if ((data_s1 & RUN_FLAG_BIT) != 8'd0) begin
							phase_d = PH_RUN;
						end else begin
							phase_d = PH_LIT;
							// literal bytes = pixels times channel count
							left_d = four_channels_q ? {hdr_len, 2'b00}
								: (10'(hdr_len) + {1'b0, hdr_len, 1'b0});
						end
					end
				endcase
			end
		end

		done1 = proc_put ? (done_q + proc_rep) : done_q;

		// last byte: zero-padded partial pixel, then one zero fill run
		part_put = last_s1 && (done1 < total) && (!rle_mode_q || phase_d == PH_LIT)
			&& (bip_d != 2'd0);
		done2    = part_put ? (done1 + PixCntW'(1)) : done1;
		fill_put = last_s1 && (done2 < total);
		fill_rep = total - done2;
		done3    = fill_put ? total : done2;

		fill_res = make_result(32'd0, four_channels_q, done2, fill_rep);
		if (proc_put) begin
			res_a = make_result(pix_or, four_channels_q, done_q, proc_rep);
		end else if (part_put) begin
			res_a = make_result(pix_d, four_channels_q, done1, PixCntW'(1));
		end else begin
			res_a = fill_res;
		end
		res_b = fill_res;

		n_res = 2'(proc_put) + 2'(part_put) + 2'(fill_put);
		if (n_res == 2'd1) begin
			res_a.image_done = done3 >= total;
		end
		if (n_res == 2'd2) begin
			res_b.image_done = done3 >= total;
		end

		done_d = done3;
		if (last_s1) begin
			phase_d   = PH_HDR;
			left_d    = 10'd0;
			run_len_d = 8'd0;
			bip_d     = 2'd0;
			pix_d     = 32'd0;
			done_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR;
			left_q    <= 10'd0;
			run_len_q <= 8'd0;
			bip_q     <= 2'd0;
			pix_q     <= 32'd0;
			done_q    <= '0;
		end else if (proc) begin
			phase_q   <= phase_d;
			left_q    <= left_d;
			run_len_q <= run_len_d;
			bip_q     <= bip_d;
			pix_q     <= pix_d;
			done_q    <= done_d;
		end
	end

	// result queue: up to two pushes, one pop per cycle
	assign pop = pix_valid && !pix_stall;

	always_ff @(posedge clk) begin
		if (proc) begin
			if (n_res != 2'd0) begin
				q_mem[wr_ptr_q] <= res_a;
			end
			if (n_res == 2'd2) begin
				q_mem[wr_ptr_q + QPtrW'(1)] <= res_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (proc) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			count_q <= count_q + (proc ? QCntW'(n_res) : '0) - QCntW'(pop);
		end
	end

	assign pix_valid   = count_q != '0;
	assign red         = q_mem[rd_ptr_q].red;
	assign green       = q_mem[rd_ptr_q].green;
	assign blue        = q_mem[rd_ptr_q].blue;
	assign alpha       = q_mem[rd_ptr_q].alpha;
	assign first_pixel = q_mem[rd_ptr_q].first_pixel;
	assign repeat_res  = q_mem[rd_ptr_q].repeat_res;
	assign image_done  = q_mem[rd_ptr_q].image_done;

endmodule
